[rtl/scan_record_stream_deframer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the record stream deframer
// Concurrent checks, clocked and disabled in reset; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SCAN_RECORD_STREAM_DEFRAMER_ASSERT_SVH
`define SCAN_RECORD_STREAM_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// property holds at every clock edge out of reset
`define SRSD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("srsd assertion failed");
// antecedent implies consequent in the same cycle
`define SRSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srsd implication failed");
// antecedent implies consequent in the next cycle
`define SRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srsd next-cycle check failed");
`else
`define SRSD_ASSERT(label, clk, rst_n, prop)
`define SRSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/srsd_pkg.sv]
// ----------------------------------------------------------------------------
// Record stream deframer package
// Parse phases, byte roles, opcodes and the per-beat result record.
// ----------------------------------------------------------------------------
package srsd_pkg;

	// parser phase
	typedef enum logic [1:0] {
		PH_OPCODE  = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	// role tag attached to every output beat
	typedef enum logic [2:0] {
		ROLE_OPCODE  = 3'd0,
		ROLE_LENGTH  = 3'd1,
		ROLE_TEXT    = 3'd2,
		ROLE_FRAME   = 3'd3,
		ROLE_SKIPPED = 3'd4,
		ROLE_END     = 3'd5
	} role_t;

	// record opcodes
	localparam logic [7:0] OP_TEXT_LEN1  = 8'd1;
	localparam logic [7:0] OP_TEXT_LEN2  = 8'd2;
	localparam logic [7:0] OP_FRAME_LEN2 = 8'd5;
	localparam logic [7:0] OP_FRAME_LEN3 = 8'd6;
	localparam logic [7:0] OP_FRAME_LEN4 = 8'd7;

	localparam int unsigned REC_LEN_W = 32;

	// one output beat
	typedef struct packed {
		role_t                  role;
		logic [7:0]             byte_out;
		logic                   record_end;
		logic                   frame_end;
		logic [REC_LEN_W-1:0]   record_length;
		logic                   truncated;
	} result_t;

endpackage

[rtl/srsd_parser.sv]
// ----------------------------------------------------------------------------
// Record parser next-state logic
// Tags one byte and computes the parser state that follows it.
// ----------------------------------------------------------------------------
module srsd_parser #(
	parameter int LENGTH_BITS = 32
) (
	input  logic [7:0]              data_byte,
	input  logic                    is_end,
	input  srsd_pkg::phase_t        phase,
	input  logic [2:0]              len_left,
	input  logic                    is_frame,
	input  logic [LENGTH_BITS-1:0]  acc,
	input  logic [LENGTH_BITS-1:0]  payload_left,
	output srsd_pkg::phase_t        phase_nxt,
	output logic [2:0]              len_left_nxt,
	output logic                    is_frame_nxt,
	output logic [LENGTH_BITS-1:0]  acc_nxt,
	output logic [LENGTH_BITS-1:0]  payload_left_nxt,
	output srsd_pkg::result_t       result
);

	logic [LENGTH_BITS+7:0] shifted;
	logic [LENGTH_BITS-1:0] acc_upd;
	logic [2:0]             left_eff;
	logic [2:0]             left_dec;
	logic [LENGTH_BITS-1:0] pl_dec;

	// length accumulate with saturation
	assign shifted  = {acc, data_byte};
	assign acc_upd  = (|shifted[LENGTH_BITS+7:LENGTH_BITS]) ? '1 : shifted[LENGTH_BITS-1:0];
	assign left_eff = (len_left == 3'd0) ? 3'd1 : len_left;
	assign left_dec = left_eff - 3'd1;
	assign pl_dec   = (payload_left != '0) ? payload_left - 1'b1 : payload_left;

	// per-byte decode
	always_comb begin
		phase_nxt        = phase;
		len_left_nxt     = len_left;
		is_frame_nxt     = is_frame;
		acc_nxt          = acc;
		payload_left_nxt = payload_left;

		result.role          = srsd_pkg::ROLE_OPCODE;
		result.byte_out      = data_byte;
		result.record_end    = 1'b0;
		result.frame_end     = 1'b0;
		result.record_length = '0;
		result.truncated     = 1'b0;

		if (is_end) begin
			result.role      = srsd_pkg::ROLE_END;
			result.byte_out  = 8'd0;
			result.truncated = (phase == srsd_pkg::PH_LENGTH) ||
				(phase == srsd_pkg::PH_PAYLOAD);
			phase_nxt        = srsd_pkg::PH_OPCODE;
			len_left_nxt     = 3'd0;
			is_frame_nxt     = 1'b0;
			acc_nxt          = '0;
			payload_left_nxt = '0;
		end else begin
			unique case (phase)
				srsd_pkg::PH_LENGTH: begin
					result.role  = srsd_pkg::ROLE_LENGTH;
					len_left_nxt = left_dec;
					acc_nxt      = acc_upd;
					if (left_dec == 3'd0) begin
						result.record_length = srsd_pkg::REC_LEN_W'(acc_upd);
						acc_nxt = '0;
						if (acc_upd == '0) begin
							// zero length ends the record here
							result.record_end = 1'b1;
							result.frame_end  = is_frame;
							phase_nxt         = srsd_pkg::PH_OPCODE;
							is_frame_nxt      = 1'b0;
							payload_left_nxt  = '0;
						end else begin
							payload_left_nxt = acc_upd;
							phase_nxt        = srsd_pkg::PH_PAYLOAD;
						end
					end
				end
				srsd_pkg::PH_PAYLOAD: begin
					result.role      = is_frame ? srsd_pkg::ROLE_FRAME : srsd_pkg::ROLE_TEXT;
					payload_left_nxt = pl_dec;
					if (pl_dec == '0) begin
						result.record_end = 1'b1;
						result.frame_end  = is_frame;
						phase_nxt         = srsd_pkg::PH_OPCODE;
						len_left_nxt      = 3'd0;
						is_frame_nxt      = 1'b0;
						acc_nxt           = '0;
					end
				end
				default: begin
					// opcode byte: pick record kind and length width
					phase_nxt        = srsd_pkg::PH_LENGTH;
					acc_nxt          = '0;
					payload_left_nxt = '0;
					is_frame_nxt     = 1'b0;
					unique case (data_byte)
						srsd_pkg::OP_TEXT_LEN1:  len_left_nxt = 3'd1;
						srsd_pkg::OP_TEXT_LEN2:  len_left_nxt = 3'd2;
						srsd_pkg::OP_FRAME_LEN2: begin
							len_left_nxt = 3'd2;
							is_frame_nxt = 1'b1;
						end
						srsd_pkg::OP_FRAME_LEN3: begin
							len_left_nxt = 3'd3;
							is_frame_nxt = 1'b1;
						end
						srsd_pkg::OP_FRAME_LEN4: begin
							len_left_nxt = 3'd4;
							is_frame_nxt = 1'b1;
						end
						default: begin
							// unknown opcode is skipped
							result.role  = srsd_pkg::ROLE_SKIPPED;
							phase_nxt    = srsd_pkg::PH_OPCODE;
							len_left_nxt = 3'd0;
						end
					endcase
				end
			endcase
		end
	end

endmodule

[rtl/scan_record_stream_deframer.sv]
// A result beat is registered and appears on m_* in the cycle after its byte is accepted.
// Throughput: one byte per clock while m_tready is high; the parser update is a single pass of logic
// between the parser state registers and the output register.
// s_tready stays high while the output register is empty or being drained.
// Reset (arst_n low, asynchronous) returns the parser to expecting an opcode
// and empties the output register.
// ----------------------------------------------------------------------------
// Record stream deframer top level
// Tags each byte of a record stream with its role and marks record ends.
// ----------------------------------------------------------------------------
`include "scan_record_stream_deframer_assert.svh"

module scan_record_stream_deframer #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] is_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] byte_out, [8] frame_end,
	                               // [40:9] record_length, [41] truncated, [47:42] zero
	output logic [2:0]  m_tuser,   // [2:0] byte_role
	output logic        m_tlast    // record_end
);

	srsd_pkg::phase_t        phase_q, phase_nxt;
	logic [2:0]              len_left_q, len_left_nxt;
	logic                    is_frame_q, is_frame_nxt;
	logic [LENGTH_BITS-1:0]  acc_q, acc_nxt;
	logic [LENGTH_BITS-1:0]  payload_q, payload_nxt;
	srsd_pkg::result_t       result;
	srsd_pkg::result_t       res_q;
	logic                    out_valid_q;
	logic                    accept;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	srsd_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parser (
		.data_byte        (s_tdata),
		.is_end           (s_tuser),
		.phase            (phase_q),
		.len_left         (len_left_q),
		.is_frame         (is_frame_q),
		.acc              (acc_q),
		.payload_left     (payload_q),
		.phase_nxt        (phase_nxt),
		.len_left_nxt     (len_left_nxt),
		.is_frame_nxt     (is_frame_nxt),
		.acc_nxt          (acc_nxt),
		.payload_left_nxt (payload_nxt),
		.result           (result)
	);

	// parser state, advanced on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= srsd_pkg::PH_OPCODE;
			len_left_q <= 3'd0;
			is_frame_q <= 1'b0;
			acc_q      <= '0;
			payload_q  <= '0;
		end else if (accept) begin
			phase_q    <= phase_nxt;
			len_left_q <= len_left_nxt;
			is_frame_q <= is_frame_nxt;
			acc_q      <= acc_nxt;
			payload_q  <= payload_nxt;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.role;
	assign m_tlast  = res_q.record_end;
	assign m_tdata  = {6'd0, res_q.truncated, res_q.record_length,
		res_q.frame_end, res_q.byte_out};

	// checks
	`SRSD_ASSERT_IMP(a_frame_end_is_record_end, clk, arst_n, out_valid_q && res_q.frame_end, res_q.record_end)
	`SRSD_ASSERT_IMP(a_trunc_only_on_end, clk, arst_n, out_valid_q && res_q.truncated, res_q.role == srsd_pkg::ROLE_END)
	`SRSD_ASSERT_NEXT(a_end_clears_phase, clk, arst_n, accept && s_tuser, phase_q == srsd_pkg::PH_OPCODE && acc_q == '0)
	`SRSD_ASSERT_IMP(a_length_has_bytes, clk, arst_n, phase_q == srsd_pkg::PH_LENGTH, len_left_q != 3'd0)
	`SRSD_ASSERT_IMP(a_payload_nonzero, clk, arst_n, phase_q == srsd_pkg::PH_PAYLOAD, payload_q != '0)

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Record stream deframer testbench
// Drives record streams into the deframer over the slave stream port and
// checks every tagged beat on the master side against a behavioral model of
// the parser or, for typed table rows, their own tag. A short table of
// directed bytes comes first, then randomly built records, truncated records
// and noise, under random sender bursts and a changing receiver stall pattern.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          LENGTH_BITS = 32;
	localparam logic [63:0] LEN_LIMIT   = (64'd1 << LENGTH_BITS) - 64'd1;
	localparam int          RANDOM_BYTES = 600;
	localparam int          MAX_REPORTS  = 10;

	// clock, reset and block ports
	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	scan_record_stream_deframer #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// directed stimulus row
	typedef struct {
		logic [7:0]        data;
		logic              is_end;
		bit                typed;
		srsd_pkg::result_t tag;
	} stim_row_t;

	stim_row_t         directed_rows[$];
	srsd_pkg::result_t tag_queue[$];

	// parser model state
	srsd_pkg::phase_t mdl_phase;
	logic [2:0]       mdl_len_left;
	logic             mdl_frame;
	logic [63:0]      mdl_acc;
	logic [63:0]      mdl_payload_left;

	// bookkeeping
	int fault_count   = 0;
	int beats_checked = 0;
	int bytes_sent    = 0;
	int noise_bytes   = 0;
	int records_sent  = 0;
	int cut_records   = 0;
	int end_markers   = 0;
	int burst_left    = 0;
	bit sender_idles  = 1'b1;

	srsd_pkg::result_t seen_tag;
	srsd_pkg::result_t wanted_tag;
	logic [9:0]        rx_cycle = '0;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("watchdog expired before the stream drained");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void clear_parser();
		mdl_phase        = srsd_pkg::PH_OPCODE;
		mdl_len_left     = '0;
		mdl_frame        = 1'b0;
		mdl_acc          = '0;
		mdl_payload_left = '0;
	endfunction

	// model of one parser step: returns the tag for one input byte
	function automatic srsd_pkg::result_t deframe_byte(logic [7:0] d, logic is_end);
		srsd_pkg::result_t r;
		logic [63:0]       acc;
		logic [2:0]        left;
		logic [2:0]        nbytes;
		logic              frame;
		r.role          = srsd_pkg::ROLE_OPCODE;
		r.byte_out      = d;
		r.record_end    = 1'b0;
		r.frame_end     = 1'b0;
		r.record_length = '0;
		r.truncated     = 1'b0;
		nbytes          = '0;
		frame           = 1'b0;
		if (is_end) begin
			r.role      = srsd_pkg::ROLE_END;
			r.byte_out  = 8'h00;
			r.truncated = (mdl_phase == srsd_pkg::PH_LENGTH) ||
				(mdl_phase == srsd_pkg::PH_PAYLOAD);
			clear_parser();
		end else if (mdl_phase == srsd_pkg::PH_LENGTH) begin
			// big-endian length, saturating at the accumulator width
			acc = (mdl_acc << 8) | 64'(d);
			if (acc > LEN_LIMIT)
				acc = LEN_LIMIT;
			mdl_acc = acc;
			left    = mdl_len_left;
			if (left == 3'd0)
				left = 3'd1;
			left         = left - 3'd1;
			mdl_len_left = left;
			r.role       = srsd_pkg::ROLE_LENGTH;
			if (left == 3'd0) begin
				r.record_length = acc[31:0];
				if (acc == 64'd0) begin
					// zero length closes the record right here
					r.record_end = 1'b1;
					r.frame_end  = mdl_frame;
					clear_parser();
				end else begin
					mdl_payload_left = acc;
					mdl_acc          = '0;
					mdl_phase        = srsd_pkg::PH_PAYLOAD;
				end
			end
		end else if (mdl_phase == srsd_pkg::PH_PAYLOAD) begin
			r.role = mdl_frame ? srsd_pkg::ROLE_FRAME : srsd_pkg::ROLE_TEXT;
			if (mdl_payload_left != 64'd0)
				mdl_payload_left = mdl_payload_left - 64'd1;
			if (mdl_payload_left == 64'd0) begin
				r.record_end = 1'b1;
				r.frame_end  = mdl_frame;
				clear_parser();
			end
		end else begin
			// opcode; the unused phase value lands here as well
			case (d)
				srsd_pkg::OP_TEXT_LEN1:  nbytes = 3'd1;
				srsd_pkg::OP_TEXT_LEN2:  nbytes = 3'd2;
				srsd_pkg::OP_FRAME_LEN2: begin nbytes = 3'd2; frame = 1'b1; end
				srsd_pkg::OP_FRAME_LEN3: begin nbytes = 3'd3; frame = 1'b1; end
				srsd_pkg::OP_FRAME_LEN4: begin nbytes = 3'd4; frame = 1'b1; end
				default:                 nbytes = 3'd0;
			endcase
			if (nbytes == 3'd0) begin
				r.role = srsd_pkg::ROLE_SKIPPED;
				clear_parser();
			end else begin
				mdl_phase        = srsd_pkg::PH_LENGTH;
				mdl_len_left     = nbytes;
				mdl_frame        = frame;
				mdl_acc          = '0;
				mdl_payload_left = '0;
			end
		end
		return r;
	endfunction

	function automatic string tag_text(srsd_pkg::result_t t);
		return $sformatf("role=%0d byte=%02h rec_end=%0b frm_end=%0b len=%08h trunc=%0b",
			t.role, t.byte_out, t.record_end, t.frame_end, t.record_length, t.truncated);
	endfunction

	task automatic log_fault(string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("ERROR: %s", msg);
	endtask

	// table rows: untyped rows are checked against the model only
	task automatic row(logic [7:0] d, logic is_end);
		stim_row_t r;
		r.data   = d;
		r.is_end = is_end;
		r.typed  = 1'b0;
		r.tag    = '0;
		directed_rows.push_back(r);
	endtask

	task automatic row_tag(logic [7:0] d, logic is_end, srsd_pkg::role_t role,
			logic rec_end, logic frm_end, logic [31:0] len, logic trunc);
		stim_row_t r;
		r.data              = d;
		r.is_end            = is_end;
		r.typed             = 1'b1;
		r.tag.role          = role;
		r.tag.byte_out      = is_end ? 8'h00 : d;
		r.tag.record_end    = rec_end;
		r.tag.frame_end     = frm_end;
		r.tag.record_length = len;
		r.tag.truncated     = trunc;
		directed_rows.push_back(r);
	endtask

	// one input beat, with sender bursts and gaps; returns the model's tag
	task automatic push_byte(logic [7:0] d, logic is_end, output srsd_pkg::result_t tag);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (sender_idles) begin
				gap = $urandom_range(0, 5);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= is_end;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
		if (is_end)
			end_markers++;
		tag = deframe_byte(d, is_end);
	endtask

	task automatic send_byte(logic [7:0] d, logic is_end);
		srsd_pkg::result_t tag;
		push_byte(d, is_end, tag);
		tag_queue.push_back(tag);
	endtask

	// sender holds off until every tag has come back
	task automatic drain_tags();
		s_tvalid <= 1'b0;
		while (tag_queue.size() != 0)
			@(posedge clk);
	endtask

	// one random record: mostly well formed, some cut short, some noise
	task automatic send_record();
		int          kind;
		int          nbytes;
		int          sent_len;
		int          sent_pay;
		int          i;
		logic [7:0]  op;
		logic [31:0] len;
		kind   = $urandom_range(0, 99);
		op     = srsd_pkg::OP_TEXT_LEN1;
		nbytes = 1;
		case ($urandom_range(0, 4))
			0: begin op = srsd_pkg::OP_TEXT_LEN1;  nbytes = 1; end
			1: begin op = srsd_pkg::OP_TEXT_LEN2;  nbytes = 2; end
			2: begin op = srsd_pkg::OP_FRAME_LEN2; nbytes = 2; end
			3: begin op = srsd_pkg::OP_FRAME_LEN3; nbytes = 3; end
			default: begin op = srsd_pkg::OP_FRAME_LEN4; nbytes = 4; end
		endcase
		sender_idles = ($urandom_range(0, 4) != 0);
		if (kind < 70) begin
			// well-formed record, short payload
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(7, 40);
			else
				len = $urandom_range(0, 6);
			send_byte(op, 1'b0);
			for (i = nbytes - 1; i >= 0; i--)
				send_byte(len[8*i +: 8], 1'b0);
			for (i = 0; i < len; i++)
				send_byte(8'($urandom), 1'b0);
			records_sent++;
		end else if (kind < 85) begin
			// long length, stream cut off in the payload or the length field
			len = $urandom;
			if ($urandom_range(0, 3) == 0)
				len = '1;
			if (nbytes < 4)
				len = len & ((32'd1 << (8 * nbytes)) - 32'd1);
			sent_len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
			sent_pay = (sent_len == nbytes) ? $urandom_range(0, 4) : 0;
			send_byte(op, 1'b0);
			for (i = nbytes - 1; i >= nbytes - sent_len; i--)
				send_byte(len[8*i +: 8], 1'b0);
			for (i = 0; i < sent_pay; i++)
				send_byte(8'($urandom), 1'b0);
			send_byte(8'($urandom), 1'b1);
			records_sent++;
			cut_records++;
		end else if (kind < 95) begin
			// noise bytes, then an end marker to resync
			sent_pay = $urandom_range(1, 3);
			for (i = 0; i < sent_pay; i++)
				send_byte(8'($urandom), 1'b0);
			send_byte(8'($urandom), 1'b1);
			noise_bytes += sent_pay + 1;
		end else begin
			send_byte(8'($urandom), 1'b1);
		end
	endtask

	// receiver stall pattern, changing with bits [9:8] of rx_cycle
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 10'd1;
		case (rx_cycle[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= 1'($urandom_range(0, 1));
			2'd2: m_tready <= (rx_cycle[2:0] != 3'd0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// output beat checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_tag.role          = srsd_pkg::role_t'(m_tuser);
			seen_tag.byte_out      = m_tdata[7:0];
			seen_tag.record_end    = m_tlast;
			seen_tag.frame_end     = m_tdata[8];
			seen_tag.record_length = m_tdata[40:9];
			seen_tag.truncated     = m_tdata[41];
			beats_checked++;
			if (tag_queue.size() == 0) begin
				log_fault($sformatf("beat with nothing expected: %s", tag_text(seen_tag)));
			end else begin
				wanted_tag = tag_queue.pop_front();
				if (seen_tag !== wanted_tag)
					log_fault($sformatf("beat %0d mismatch\n  expected %s\n  actual   %s",
						beats_checked, tag_text(wanted_tag), tag_text(seen_tag)));
			end
		end
	end

	// main sequence
	initial begin
		int                n;
		int                wait_cycles;
		srsd_pkg::result_t tag;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tuser  <= 1'b0;
		clear_parser();

		// directed table
		row_tag(8'hFF, 1'b1, srsd_pkg::ROLE_END, 1'b0, 1'b0, 32'd0, 1'b0);
		row_tag(8'h00, 1'b0, srsd_pkg::ROLE_SKIPPED, 1'b0, 1'b0, 32'd0, 1'b0);
		row_tag(8'hFF, 1'b0, srsd_pkg::ROLE_SKIPPED, 1'b0, 1'b0, 32'd0, 1'b0);
		row_tag(srsd_pkg::OP_TEXT_LEN1, 1'b0, srsd_pkg::ROLE_OPCODE, 1'b0, 1'b0, 32'd0, 1'b0);
		row_tag(8'h00, 1'b0, srsd_pkg::ROLE_LENGTH, 1'b1, 1'b0, 32'd0, 1'b0);
		row_tag(srsd_pkg::OP_FRAME_LEN2, 1'b0, srsd_pkg::ROLE_OPCODE, 1'b0, 1'b0, 32'd0, 1'b0);
		row(8'h00, 1'b0);
		row_tag(8'h00, 1'b0, srsd_pkg::ROLE_LENGTH, 1'b1, 1'b1, 32'd0, 1'b0);
		row(srsd_pkg::OP_TEXT_LEN2, 1'b0);
		row(8'h00, 1'b0);
		row(8'h02, 1'b0);
		row(8'hA5, 1'b0);
		row(8'h5A, 1'b0);
		row(srsd_pkg::OP_FRAME_LEN3, 1'b0);
		row(8'h00, 1'b0);
		row(8'h00, 1'b0);
		row(8'h01, 1'b0);
		row(8'hFF, 1'b0);
		row(srsd_pkg::OP_FRAME_LEN4, 1'b0);
		row(8'hFF, 1'b0);
		row(8'hFF, 1'b0);
		row(8'hFF, 1'b0);
		row_tag(8'hFF, 1'b0, srsd_pkg::ROLE_LENGTH, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);
		row_tag(8'h80, 1'b1, srsd_pkg::ROLE_END, 1'b0, 1'b0, 32'd0, 1'b1);
		row(srsd_pkg::OP_TEXT_LEN1, 1'b0);
		row_tag(8'h7F, 1'b1, srsd_pkg::ROLE_END, 1'b0, 1'b0, 32'd0, 1'b1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the table; typed rows carry their own tag
		foreach (directed_rows[i]) begin
			push_byte(directed_rows[i].data, directed_rows[i].is_end, tag);
			tag_queue.push_back(directed_rows[i].typed ? directed_rows[i].tag : tag);
		end
		n = bytes_sent;
		drain_tags();

		// random records
		while (bytes_sent - n - noise_bytes < RANDOM_BYTES) begin
			send_record();
			if ($urandom_range(0, 39) == 0)
				drain_tags();
		end

		// wait for the last tags, bounded by a timeout, then check that none is left
		s_tvalid <= 1'b0;
		wait_cycles = 0;
		while (tag_queue.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (tag_queue.size() != 0)
			log_fault($sformatf("%0d expected beats never arrived", tag_queue.size()));

		$display("Run covered %0d input bytes (%0d directed), %0d records (%0d cut short),",
			bytes_sent, n, records_sent, cut_records);
		$display("  %0d end markers and %0d checked output beats", end_markers, beats_checked);
		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
